// File: rtl/rdm_pkg.sv
// Package for the Redcode DIV/MOD execute unit.
// Holds request/result payload types, modifier and op codes, and queue entry types.
// No dependencies.
package rdm_pkg;

  localparam int SIZE_BITS = 16;
  localparam logic [SIZE_BITS-1:0] CORE_SIZE_RESET = 16'd8000;
  localparam logic [SIZE_BITS-1:0] CORE_SIZE_MIN   = 16'd2;

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MOD = 1'b1;

  localparam logic [2:0] MOD_A  = 3'd0;
  localparam logic [2:0] MOD_B  = 3'd1;
  localparam logic [2:0] MOD_AB = 3'd2;
  localparam logic [2:0] MOD_BA = 3'd3;
  localparam logic [2:0] MOD_F  = 3'd4;
  localparam logic [2:0] MOD_X  = 3'd5;
  localparam logic [2:0] MOD_I  = 3'd6;

  typedef struct packed {
    logic                 op;
    logic [2:0]           modifier;
    logic [SIZE_BITS-1:0] pc;
    logic [SIZE_BITS-1:0] src_a_value;
    logic [SIZE_BITS-1:0] src_b_value;
    logic [SIZE_BITS-1:0] dst_a_value;
    logic [SIZE_BITS-1:0] dst_b_value;
  } req_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] new_dst_a;
    logic [SIZE_BITS-1:0] new_dst_b;
    logic                 write_a;
    logic                 write_b;
    logic                 queue_next;
    logic [SIZE_BITS-1:0] next_pc;
  } res_t;

  typedef struct packed {
    logic op;
    logic use_a;
    logic use_b;
    logic a_div_sb;
    logic b_div_sa;
  } cls_t;

  typedef struct packed {
    req_t req;
    cls_t cls;
  } ent_t;

endpackage

// File: rtl/rdm_front.sv
// Front end of the Redcode DIV/MOD execute unit: accepts requests and classifies
// the modifier into field pair usage. Depends on rdm_pkg.
module rdm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rdm_pkg::req_t req,
  output logic          busy,
  input  logic          full,
  output logic          push,
  output rdm_pkg::ent_t push_ent
);

  logic          vld;
  rdm_pkg::ent_t ent;
  rdm_pkg::cls_t cls_next;
  logic          accept;

  assign busy     = vld && full;
  assign push     = vld && !full;
  assign push_ent = ent;
  assign accept   = start && !busy;

  always_comb begin
    cls_next    = '0;
    cls_next.op = req.op;
    unique case (req.modifier) inside
      rdm_pkg::MOD_A: begin
        cls_next.use_a = 1'b1;
      end
      rdm_pkg::MOD_B: begin
        cls_next.use_b = 1'b1;
      end
      rdm_pkg::MOD_AB: begin
        cls_next.use_b    = 1'b1;
        cls_next.b_div_sa = 1'b1;
      end
      rdm_pkg::MOD_BA: begin
        cls_next.use_a    = 1'b1;
        cls_next.a_div_sb = 1'b1;
      end
      rdm_pkg::MOD_F, rdm_pkg::MOD_I: begin
        cls_next.use_a = 1'b1;
        cls_next.use_b = 1'b1;
      end
      rdm_pkg::MOD_X: begin
        cls_next.use_a    = 1'b1;
        cls_next.use_b    = 1'b1;
        cls_next.a_div_sb = 1'b1;
        cls_next.b_div_sa = 1'b1;
      end
      default: begin
        cls_next.use_a = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (accept) begin
      vld <= 1'b1;
    end else if (push) begin
      vld <= 1'b0;
    end
    if (accept) begin
      ent.req <= req;
      ent.cls <= cls_next;
    end
  end

endmodule

// File: rtl/rdm_queue.sv
// Two-entry request queue between front end and execution back end.
// Depends on rdm_pkg.
module rdm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rdm_pkg::ent_t push_ent,
  output logic          full,
  input  logic          pop,
  output logic          vld,
  output rdm_pkg::ent_t pop_ent
);

  rdm_pkg::ent_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_pop;

  assign vld     = count != 2'd0;
  assign full    = count == 2'd2;
  assign pop_ent = slots[rd_ptr];
  assign do_pop  = pop && vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!push && do_pop) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

// File: rtl/rdm_divpipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
// Carries a side vector along with each item. No dependencies.
module rdm_divpipe #(
  parameter int LANES     = 1,
  parameter int NUM_BITS  = 16,
  parameter int DEN_BITS  = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic [LANES-1:0][NUM_BITS-1:0]      in_num,
  input  logic [LANES-1:0][DEN_BITS-1:0]      in_den,
  input  logic [SIDE_BITS-1:0]                in_side,
  output logic                                out_vld,
  output logic [LANES-1:0][NUM_BITS-1:0]      out_quo,
  output logic [LANES-1:0][DEN_BITS-1:0]      out_rem,
  output logic [SIDE_BITS-1:0]                out_side
);

  logic                           vld  [NUM_BITS+1];
  logic [LANES-1:0][NUM_BITS-1:0] num  [NUM_BITS+1];
  logic [LANES-1:0][DEN_BITS-1:0] den  [NUM_BITS+1];
  logic [LANES-1:0][DEN_BITS-1:0] rem  [NUM_BITS+1];
  logic [SIDE_BITS-1:0]           side [NUM_BITS+1];

  assign vld[0]  = in_vld;
  assign num[0]  = in_num;
  assign den[0]  = in_den;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [LANES-1:0][NUM_BITS-1:0] num_next;
    logic [LANES-1:0][DEN_BITS-1:0] rem_next;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      logic              ge;

      assign trial = {rem[s][l], num[s][l][NUM_BITS-1]};
      assign ge    = trial >= {1'b0, den[s][l]};
      assign diff  = trial - {1'b0, den[s][l]};
      assign rem_next[l] = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      assign num_next[l] = {num[s][l][NUM_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      num[s+1]  <= num_next;
      rem[s+1]  <= rem_next;
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign out_vld  = vld[NUM_BITS];
  assign out_quo  = num[NUM_BITS];
  assign out_rem  = rem[NUM_BITS];
  assign out_side = side[NUM_BITS];

endmodule

// File: rtl/rdm_back.sv
// Back end of the Redcode DIV/MOD execute unit: reduces operands modulo core size,
// works the field pairs and registers the result. Depends on rdm_pkg, rdm_divpipe.
module rdm_back #(
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rdm_pkg::SIZE_BITS-1:0]  size,
  input  logic                           in_vld,
  input  rdm_pkg::ent_t                  in_ent,
  output logic                           done,
  output rdm_pkg::res_t                  res
);

  localparam int SB = rdm_pkg::SIZE_BITS;
  localparam int RED_LANES = 5;

  typedef struct packed {
    logic          op;
    logic          use_a;
    logic          use_b;
    logic          zero_a;
    logic          zero_b;
    logic [SB-1:0] da;
    logic [SB-1:0] db;
    logic [SB-1:0] npc;
  } mid_t;

  logic [RED_LANES-1:0][VALUE_BITS-1:0] red_num;
  logic [RED_LANES-1:0][SB-1:0]         red_den;
  logic                                 red_vld;
  logic [RED_LANES-1:0][VALUE_BITS-1:0] red_quo;
  logic [RED_LANES-1:0][SB-1:0]         red_rem;
  logic [$bits(rdm_pkg::cls_t)-1:0]     red_side;
  rdm_pkg::cls_t                        cls;

  logic [SB-1:0] pc_r, sa_r, sb_r, da_r, db_r;
  logic [SB-1:0] div_a, div_b;
  logic [SB:0]   pc_inc;
  mid_t          mid;

  logic [1:0][SB-1:0]   pair_num;
  logic [1:0][SB-1:0]   pair_den;
  logic                 pair_vld;
  logic [1:0][SB-1:0]   pair_quo;
  logic [1:0][SB-1:0]   pair_rem;
  logic [$bits(mid_t)-1:0] pair_side;
  mid_t                 fin;
  logic                 wa, wb;
  rdm_pkg::res_t        res_next;

  assign red_num[0] = VALUE_BITS'(in_ent.req.pc);
  assign red_num[1] = VALUE_BITS'(in_ent.req.src_a_value);
  assign red_num[2] = VALUE_BITS'(in_ent.req.src_b_value);
  assign red_num[3] = VALUE_BITS'(in_ent.req.dst_a_value);
  assign red_num[4] = VALUE_BITS'(in_ent.req.dst_b_value);
  assign red_den    = {RED_LANES{size}};

  rdm_divpipe #(
    .LANES     (RED_LANES),
    .NUM_BITS  (VALUE_BITS),
    .DEN_BITS  (SB),
    .SIDE_BITS ($bits(rdm_pkg::cls_t))
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_vld),
    .in_num   (red_num),
    .in_den   (red_den),
    .in_side  (in_ent.cls),
    .out_vld  (red_vld),
    .out_quo  (red_quo),
    .out_rem  (red_rem),
    .out_side (red_side)
  );

  assign cls  = rdm_pkg::cls_t'(red_side);
  assign pc_r = red_rem[0];
  assign sa_r = red_rem[1];
  assign sb_r = red_rem[2];
  assign da_r = red_rem[3];
  assign db_r = red_rem[4];

  assign div_a  = cls.a_div_sb ? sb_r : sa_r;
  assign div_b  = cls.b_div_sa ? sa_r : sb_r;
  assign pc_inc = {1'b0, pc_r} + {{SB{1'b0}}, 1'b1};

  always_comb begin
    mid.op     = cls.op;
    mid.use_a  = cls.use_a;
    mid.use_b  = cls.use_b;
    mid.zero_a = div_a == '0;
    mid.zero_b = div_b == '0;
    mid.da     = da_r;
    mid.db     = db_r;
    mid.npc    = (pc_inc == {1'b0, size}) ? '0 : pc_inc[SB-1:0];
  end

  assign pair_num[0] = da_r;
  assign pair_num[1] = db_r;
  assign pair_den[0] = div_a;
  assign pair_den[1] = div_b;

  rdm_divpipe #(
    .LANES     (2),
    .NUM_BITS  (SB),
    .DEN_BITS  (SB),
    .SIDE_BITS ($bits(mid_t))
  ) u_pair (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (red_vld && (red_quo[0] == red_quo[0])),
    .in_num   (pair_num),
    .in_den   (pair_den),
    .in_side  (mid),
    .out_vld  (pair_vld),
    .out_quo  (pair_quo),
    .out_rem  (pair_rem),
    .out_side (pair_side)
  );

  assign fin = mid_t'(pair_side);
  assign wa  = fin.use_a && !fin.zero_a;
  assign wb  = fin.use_b && !fin.zero_b;

  always_comb begin
    res_next.new_dst_a  = wa ? ((fin.op == rdm_pkg::OP_MOD) ? pair_rem[0] : pair_quo[0])
                             : fin.da;
    res_next.new_dst_b  = wb ? ((fin.op == rdm_pkg::OP_MOD) ? pair_rem[1] : pair_quo[1])
                             : fin.db;
    res_next.write_a    = wa;
    res_next.write_b    = wb;
    res_next.queue_next = !((fin.use_a && fin.zero_a) || (fin.use_b && fin.zero_b));
    res_next.next_pc    = fin.npc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pair_vld;
    end
    res <= res_next;
  end

endmodule

// File: rtl/redcode_div_mod_unit_core.sv
// Top level of the Redcode DIV/MOD execute unit: core size register, front end,
// request queue and back end. Depends on rdm_pkg, rdm_front, rdm_queue, rdm_back.
//
// Takes one request per clock cycle (start while busy is low) and returns one
// result per request, in order; done marks the single cycle in which the result
// is valid and the receiver cannot stall it. The result is worked out by two
// bit-per-stage divider pipelines: one that reduces every field modulo core
// size (VALUE_BITS stages) and one that works the field pairs (16 stages). The
// back end drains the queue every cycle, so busy stays low in normal operation.
// Write core_size only while no request is in flight; values 0 and 1 act as 2.
module redcode_div_mod_unit_core #(
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rdm_pkg::req_t                 req,
  output logic                          done,
  output rdm_pkg::res_t                 res,
  input  logic                          cfg_we,
  input  logic [rdm_pkg::SIZE_BITS-1:0] cfg_wdata
);

  logic [rdm_pkg::SIZE_BITS-1:0] core_size;
  logic [rdm_pkg::SIZE_BITS-1:0] eff_size;
  logic                          q_full;
  logic                          push;
  rdm_pkg::ent_t                 push_ent;
  logic                          q_vld;
  rdm_pkg::ent_t                 q_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_size <= rdm_pkg::CORE_SIZE_RESET;
    end else if (cfg_we) begin
      core_size <= cfg_wdata;
    end
  end

  assign eff_size = (core_size < rdm_pkg::CORE_SIZE_MIN) ? rdm_pkg::CORE_SIZE_MIN : core_size;

  rdm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .full     (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  rdm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_vld),
    .vld      (q_vld),
    .pop_ent  (q_ent)
  );

  rdm_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .size   (eff_size),
    .in_vld (q_vld),
    .in_ent (q_ent),
    .done   (done),
    .res    (res)
  );

endmodule

// File: tb/sv/redcode_div_mod_unit_core_tb.sv
// Testbench for redcode_div_mod_unit_core: directed and random DIV/MOD requests
// across several core sizes, each result checked against a behavioral
// predictor or hand-written values. Depends on rdm_pkg, redcode_div_mod_unit_core.
`timescale 1ns / 100ps

module redcode_div_mod_unit_core_tb;

  localparam int VALUE_BITS = 16;
  localparam int LATENCY = VALUE_BITS + 18;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 100;
  localparam int SB = rdm_pkg::SIZE_BITS;
  localparam logic [2:0] MOD_NONE = 3'd7;

  typedef struct {
    rdm_pkg::req_t rq;
    bit            typed;
    rdm_pkg::res_t want;
  } dir_row_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  rdm_pkg::req_t req = '0;
  logic          done;
  rdm_pkg::res_t res;
  logic          cfg_we = 1'b0;
  logic [SB-1:0] cfg_wdata = '0;

  logic [SB-1:0] size_now;
  bit            idle_on;
  rdm_pkg::res_t pending_res[$];
  dir_row_t      dir_rows[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   quiet_cycles = 0;
  rdm_pkg::res_t got_want;

  redcode_div_mod_unit_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [SB-1:0] cs);
    return (cs < 2) ? 2 : int'(cs);
  endfunction

  function automatic rdm_pkg::res_t divmod_predict(rdm_pkg::req_t r, logic [SB-1:0] cs);
    int unsigned m, pc, sa, sb, da, db, div_a, div_b, na, nb, npc;
    bit use_a, use_b, wa, wb;
    rdm_pkg::res_t o;
    m = eff_size(cs);
    pc = r.pc % m;
    sa = r.src_a_value % m;
    sb = r.src_b_value % m;
    da = r.dst_a_value % m;
    db = r.dst_b_value % m;
    na = da;
    nb = db;
    use_a = 0;
    use_b = 0;
    div_a = 0;
    div_b = 0;
    wa = 0;
    wb = 0;
    case (r.modifier)
      rdm_pkg::MOD_A: begin
        use_a = 1; div_a = sa;
      end
      rdm_pkg::MOD_B: begin
        use_b = 1; div_b = sb;
      end
      rdm_pkg::MOD_AB: begin
        use_b = 1; div_b = sa;
      end
      rdm_pkg::MOD_BA: begin
        use_a = 1; div_a = sb;
      end
      rdm_pkg::MOD_F, rdm_pkg::MOD_I: begin
        use_a = 1; div_a = sa; use_b = 1; div_b = sb;
      end
      rdm_pkg::MOD_X: begin
        use_a = 1; div_a = sb; use_b = 1; div_b = sa;
      end
      default: ;
    endcase
    if (use_a && div_a != 0) begin
      wa = 1;
      na = ((r.op == rdm_pkg::OP_MOD) ? da % div_a : da / div_a) % m;
    end
    if (use_b && div_b != 0) begin
      wb = 1;
      nb = ((r.op == rdm_pkg::OP_MOD) ? db % div_b : db / div_b) % m;
    end
    npc = (pc + 1) % m;
    o.new_dst_a = na[SB-1:0];
    o.new_dst_b = nb[SB-1:0];
    o.write_a = wa;
    o.write_b = wb;
    o.queue_next = !((use_a && !wa) || (use_b && !wb));
    o.next_pc = npc[SB-1:0];
    return o;
  endfunction

  function automatic logic [SB-1:0] pick_value(int unsigned m);
    case ($urandom_range(0, 9))
      0, 1: return SB'($urandom_range(0, 3));
      2, 3, 4, 5: return SB'($urandom_range(0, m - 1));
      6: return SB'(m);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic rdm_pkg::req_t random_req(logic [SB-1:0] cs);
    rdm_pkg::req_t r;
    int unsigned m;
    m = eff_size(cs);
    r.op = 1'($urandom);
    r.modifier = 3'($urandom_range(0, 7));
    r.pc = ($urandom_range(0, 3) == 0) ? SB'($urandom)
                                       : SB'($urandom_range(0, m - 1));
    r.src_a_value = pick_value(m);
    r.src_b_value = pick_value(m);
    r.dst_a_value = pick_value(m);
    r.dst_b_value = pick_value(m);
    return r;
  endfunction

  function automatic void add_row(logic op, logic [2:0] modf, logic [15:0] pc,
                                  logic [15:0] sa, logic [15:0] sb,
                                  logic [15:0] da, logic [15:0] db, bit typed,
                                  logic [15:0] na, logic [15:0] nb, logic wa,
                                  logic wb, logic q, logic [15:0] npc);
    dir_row_t row;
    row.rq = '{op, modf, pc, sa, sb, da, db};
    row.typed = typed;
    row.want = '{na, nb, wa, wb, q, npc};
    dir_rows.push_back(row);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // enter and leave at a falling edge; start stays high between back-to-back requests
  task automatic issue(rdm_pkg::req_t r, rdm_pkg::res_t want);
    while (idle_on && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      req <= rdm_pkg::req_t'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_res.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_size(logic [SB-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_now = v;
  endtask

  task automatic run_random(int unsigned n);
    rdm_pkg::req_t r;
    repeat (n) begin
      r = random_req(size_now);
      issue(r, divmod_predict(r, size_now));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_res.size() == 0) begin
        report("unrequested result", 1, 0);
      end else begin
        got_want = pending_res.pop_front();
        if (res.new_dst_a !== got_want.new_dst_a)
          report("new_dst_a", res.new_dst_a, got_want.new_dst_a);
        if (res.new_dst_b !== got_want.new_dst_b)
          report("new_dst_b", res.new_dst_b, got_want.new_dst_b);
        if (res.write_a !== got_want.write_a)
          report("write_a", res.write_a, got_want.write_a);
        if (res.write_b !== got_want.write_b)
          report("write_b", res.write_b, got_want.write_b);
        if (res.queue_next !== got_want.queue_next)
          report("queue_next", res.queue_next, got_want.queue_next);
        if (res.next_pc !== got_want.next_pc)
          report("next_pc", res.next_pc, got_want.next_pc);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    idle_on = 1;
    size_now = rdm_pkg::CORE_SIZE_RESET;

    // expected values below assume the reset core size
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_A,  0,     0,     5,   100,   200, 1,
            100, 200, 0, 0, 0, 1);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_B,  7999,  3,     7,   50,    70,  1,
            50, 10, 0, 1, 1, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_AB, 65535, 0,     5,   4,     9,   1,
            4, 9, 0, 0, 0, 1536);
    add_row(rdm_pkg::OP_DIV, MOD_NONE, 5,     1,     1,   1,     1,   1,
            1, 1, 0, 0, 1, 6);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_F, 65535, 65535, 65535, 65535, 65535, 1,
            1, 1, 1, 1, 1, 1536);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_F, 65535, 65535, 65535, 65535, 65535, 1,
            0, 0, 1, 1, 1, 1536);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_BA, 100,  9,     4,     4000,  1,     0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_BA, 200,  0,     7,     7999,  3,     0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_X,  7998, 0,     13,    7777,  300,   0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_X,  1,    11,    6,     123,   4567,  0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_I,  2,    8000,  2,     7999,  7999,  0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_I,  3,    3,     16000, 8005,  65000, 0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_F,  0,    0,     0,     0,     0,     0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_A,  4,    1,     0,     65535, 0,     0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_AB, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555,
            16'hAAAA, 0, 0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, rdm_pkg::MOD_B,  16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA,
            16'h5555, 0, 0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_MOD, MOD_NONE, 8000, 0,   0,     9,     10,    0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_A,  7999, 1,     1,     7999,  8000,  0,
            0, 0, 0, 0, 0, 0);
    add_row(rdm_pkg::OP_DIV, rdm_pkg::MOD_X,  42,   8001,  8002,  8003,  8004,  0,
            0, 0, 0, 0, 0, 0);

    rst <= 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].rq,
            dir_rows[i].typed ? dir_rows[i].want : divmod_predict(dir_rows[i].rq, size_now));
    end
    run_random(PHASE_ITEMS);

    drain();
    write_size(rdm_pkg::CORE_SIZE_MIN);
    run_random(PHASE_ITEMS);
    drain();
    write_size(16'hFFFF);
    run_random(PHASE_ITEMS);
    drain();
    write_size(16'd0);
    run_random(PHASE_ITEMS / 2);
    drain();
    write_size(16'd1);
    run_random(PHASE_ITEMS / 2);
    drain();
    write_size(16'd7);
    run_random(PHASE_ITEMS);
    drain();
    write_size(rdm_pkg::CORE_SIZE_RESET);
    idle_on = 0;
    run_random(PHASE_ITEMS * 2);
    idle_on = 1;
    drain();
    write_size(SB'($urandom_range(2, 65535)));
    run_random(PHASE_ITEMS);
    drain();
    write_size(16'd100);
    run_random(PHASE_ITEMS);

    drain();
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
